>>> rtl/iws_pkg.sv
// Shared types, constants and character-class helpers for the identifier word splitter.
`timescale 1ns / 1ps
`default_nettype none
package iws_pkg;

    // Job queue depth between front and back; must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [6:0] CASE_DELTA = 7'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_last;
    } t_in_item;

    typedef struct packed {
        logic [6:0] letter;
        logic       word_first;
        logic       end_of_line;
        logic       run_last;
    } t_out_item;

    // Everything one input byte asks the back end to emit, in order:
    // the held character, the final word byte, the end-of-line marker.
    typedef struct packed {
        logic       held_vld;
        logic [6:0] held_letter;
        logic       held_first;
        logic       new_vld;
        logic [6:0] new_letter;
        logic       new_first;
        logic       eol;
    } t_job;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_upper(c) || is_lower(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
    endfunction

    function automatic logic [6:0] to_lower(input logic [6:0] c);
        return is_upper({1'b0, c}) ? (c + CASE_DELTA) : c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/iws_front.sv
// Front end: accepts bytes, holds one word byte of lookahead and builds emit jobs.
`timescale 1ns / 1ps
`default_nettype none
module iws_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  iws_pkg::t_in_item  i_data,
    output logic               o_ready,
    input  wire                i_q_ready,
    output logic               o_push,
    output iws_pkg::t_job      o_job
);

    logic [6:0] r_held_char;
    logic       r_held_valid;
    logic       r_fresh;
    logic       r_before_upper;

    logic [6:0] n_held_char;
    logic       n_held_valid;
    logic       n_fresh;
    logic       n_before_upper;

    logic       w_accept;
    logic       w_word;
    logic       w_b_upper;
    logic       w_held_upper;

    assign o_ready      = i_q_ready;
    assign w_accept     = i_valid && i_q_ready;
    assign w_word       = iws_pkg::is_word(i_data.in_byte);
    assign w_b_upper    = iws_pkg::is_upper(i_data.in_byte);
    assign w_held_upper = r_held_valid && iws_pkg::is_upper({1'b0, r_held_char});

    always_comb begin
        o_job.held_vld    = r_held_valid;
        o_job.held_letter = iws_pkg::to_lower(r_held_char);
        // Held byte starts a word after a separator, at an upper after a non-upper,
        // or at the last upper of an upper run that a lowercase letter follows.
        o_job.held_first  = r_fresh || (iws_pkg::is_upper({1'b0, r_held_char}) &&
                            (!r_before_upper || iws_pkg::is_lower(i_data.in_byte)));
        o_job.new_vld     = i_data.line_last && w_word;
        o_job.new_letter  = iws_pkg::to_lower(i_data.in_byte[6:0]);
        // Final byte of the line has no lowercase lookahead.
        o_job.new_first   = !r_held_valid || (w_b_upper && !w_held_upper);
        o_job.eol         = i_data.line_last;
    end

    // Drop transactions that produce nothing.
    assign o_push = w_accept && (r_held_valid || i_data.line_last);

    always_comb begin
        n_held_char    = r_held_char;
        n_held_valid   = r_held_valid;
        n_fresh        = r_fresh;
        n_before_upper = r_before_upper;
        if (w_accept) begin
            if (w_word && !i_data.line_last) begin
                n_held_char    = i_data.in_byte[6:0];
                n_held_valid   = 1'b1;
                n_fresh        = !r_held_valid;
                n_before_upper = w_held_upper;
            end else begin
                n_held_char    = '0;
                n_held_valid   = 1'b0;
                n_fresh        = 1'b0;
                n_before_upper = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char    <= '0;
            r_held_valid   <= 1'b0;
            r_fresh        <= 1'b0;
            r_before_upper <= 1'b0;
        end else begin
            r_held_char    <= n_held_char;
            r_held_valid   <= n_held_valid;
            r_fresh        <= n_fresh;
            r_before_upper <= n_before_upper;
        end
    end

endmodule
`default_nettype wire

>>> rtl/iws_queue.sv
// Short job queue that decouples the front end from the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module iws_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  iws_pkg::t_job       i_job,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_pop,
    output iws_pkg::t_job       o_job
);

    iws_pkg::t_job                r_mem [iws_pkg::QDEPTH];
    logic [iws_pkg::QAW-1:0]      r_wr_ptr;
    logic [iws_pkg::QAW-1:0]      r_rd_ptr;
    logic [iws_pkg::QCW-1:0]      r_count;

    logic                         w_do_push;
    logic                         w_do_pop;

    assign o_ready   = (r_count != iws_pkg::QCW'(iws_pkg::QDEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/iws_back.sv
// Back end: walks each job's parts, one result per unstalled cycle into the output register.
`timescale 1ns / 1ps
`default_nettype none
module iws_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  iws_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output iws_pkg::t_out_item  o_data
);

    // Parts of the head job already emitted: held, new, end-of-line.
    logic [2:0]          r_done;
    logic [2:0]          n_done;
    logic                r_valid;
    iws_pkg::t_out_item  r_data;

    logic                w_p_held;
    logic                w_p_new;
    logic                w_p_eol;
    logic                w_load;
    logic [2:0]          w_sel;
    iws_pkg::t_out_item  w_item;

    assign w_p_held = i_job.held_vld && !r_done[0];
    assign w_p_new  = i_job.new_vld && !r_done[1];
    assign w_p_eol  = i_job.eol && !r_done[2];
    assign w_load   = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        w_item = '0;
        w_sel  = 3'b100;
        if (w_p_held) begin
            w_sel              = 3'b001;
            w_item.letter      = i_job.held_letter;
            w_item.word_first  = i_job.held_first;
            w_item.run_last    = !(w_p_new || w_p_eol);
        end else if (w_p_new) begin
            w_sel              = 3'b010;
            w_item.letter      = i_job.new_letter;
            w_item.word_first  = i_job.new_first;
            w_item.run_last    = !w_p_eol;
        end else begin
            w_item.end_of_line = 1'b1;
            w_item.run_last    = 1'b1;
        end
    end

    // Retire the job with its last part; otherwise mark the part done.
    assign o_pop  = w_load && w_item.run_last;
    assign n_done = o_pop ? 3'b000 : (r_done | w_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_done  <= n_done;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= w_item;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> rtl/identifier_word_splitter_top.sv
// Top level of the identifier word splitter: front end, job queue, output serializer.
// A result passes through the job queue and the output register. Throughput: one
// byte per cycle while the queue has room; a line-end byte yields up to three
// results via the single output register; the four-entry queue absorbs the burst.
// Reset: synchronous active-low i_rst_n empties the queue and the output register
// and clears the held byte.
`timescale 1ns / 1ps
`default_nettype none
module identifier_word_splitter_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  iws_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output iws_pkg::t_out_item  o_out_data
);

    logic           w_push;
    logic           w_q_ready;
    iws_pkg::t_job  w_front_job;
    logic           w_q_valid;
    logic           w_pop;
    iws_pkg::t_job  w_head_job;

    iws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_ready   (o_in_ready),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    iws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_head_job)
    );

    iws_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

    a_eol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_line |->
            o_out_data.run_last && !o_out_data.word_first && (o_out_data.letter == 7'd0))
        else $error("end-of-line transaction malformed");

    a_no_upper_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.end_of_line |->
            !((o_out_data.letter >= 7'h41) && (o_out_data.letter <= 7'h5A)))
        else $error("uppercase letter reached the output");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_valid && !(o_out_valid && !i_out_ready) |=> !o_out_valid)
        else $error("output valid without a queued job");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid && (!o_out_valid || i_out_ready))
        else $error("job retired without an output load");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for identifier_word_splitter_top: directed lines, random lines, stalls.
`timescale 1ns / 1ps
module testbench;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_BYTES    = 40;

    typedef enum int {
        RUN_LOWER,
        RUN_UPPER,
        RUN_DIGIT,
        RUN_PUNCT,
        RUN_RAW
    } t_run_class;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    iws_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    iws_pkg::t_out_item o_out_data;

    identifier_word_splitter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Splitter state as the expected behavior sees it
    logic [6:0]         held_char;
    logic               held_valid;
    logic               held_fresh;
    logic               prior_cap;
    iws_pkg::t_out_item pending_chars[$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_request;
    int          error_count;
    int          quiet_cycles = 0;
    t_run_class  run_class;

    function automatic bit cap_letter(input logic [7:0] c);
        return (c >= iws_pkg::CH_UPPER_A) && (c <= iws_pkg::CH_UPPER_Z);
    endfunction

    function automatic bit small_letter(input logic [7:0] c);
        return (c >= iws_pkg::CH_LOWER_A) && (c <= iws_pkg::CH_LOWER_Z);
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return cap_letter(c) || small_letter(c) ||
               ((c >= iws_pkg::CH_DIGIT_0) && (c <= iws_pkg::CH_DIGIT_9));
    endfunction

    function automatic logic [6:0] fold_case(input logic [6:0] c);
        return cap_letter({1'b0, c}) ? c + iws_pkg::CASE_DELTA : c;
    endfunction

    // Does the held character open a word, given the byte after it?
    function automatic bit held_opens_word(input logic [7:0] next);
        if (held_fresh)
            return 1'b1;
        if (!cap_letter({1'b0, held_char}))
            return 1'b0;
        if (!prior_cap)
            return 1'b1;
        return small_letter(next);
    endfunction

    function automatic void clear_held();
        held_char  = '0;
        held_valid = 1'b0;
        held_fresh = 1'b0;
        prior_cap  = 1'b0;
    endfunction

    function automatic void predict_split(input iws_pkg::t_in_item item);
        iws_pkg::t_out_item burst[$];
        iws_pkg::t_out_item r;
        bit                 had_held;
        bit                 had_cap;
        had_held = held_valid;
        had_cap  = held_valid && cap_letter({1'b0, held_char});
        if (held_valid) begin
            r = '0;
            r.letter     = fold_case(held_char);
            r.word_first = held_opens_word(item.in_byte);
            burst.push_back(r);
        end
        if (word_char(item.in_byte)) begin
            held_char  = item.in_byte[6:0];
            held_valid = 1'b1;
            held_fresh = !had_held;
            prior_cap  = had_cap;
        end else begin
            clear_held();
        end
        if (item.line_last) begin
            // line end: no lowercase lookahead for the final word byte
            if (held_valid) begin
                r = '0;
                r.letter     = fold_case(held_char);
                r.word_first = held_opens_word(8'h00);
                burst.push_back(r);
            end
            r = '0;
            r.end_of_line = 1'b1;
            burst.push_back(r);
            clear_held();
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[k])
            pending_chars.push_back(burst[k]);
    endfunction

    // Stay in a character class for a while so real identifiers form
    function automatic logic [7:0] random_byte();
        if ($urandom_range(99) >= 60)
            run_class = t_run_class'($urandom_range(4));
        case (run_class)
            RUN_LOWER: return iws_pkg::CH_LOWER_A + 8'($urandom_range(25));
            RUN_UPPER: return iws_pkg::CH_UPPER_A + 8'($urandom_range(25));
            RUN_DIGIT: return iws_pkg::CH_DIGIT_0 + 8'($urandom_range(9));
            RUN_PUNCT: begin
                case ($urandom_range(3))
                    0: return "_";
                    1: return "-";
                    2: return " ";
                    default: return ".";
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        iws_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected result: letter=%0h word_first=%0b end_of_line=%0b",
                       o_out_data.letter, o_out_data.word_first, o_out_data.end_of_line);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_out_data.letter !== want.letter) begin
                    $error("letter: expected %0h, got %0h", want.letter, o_out_data.letter);
                    error_count++;
                end
                if (o_out_data.word_first !== want.word_first) begin
                    $error("word_first: expected %0b, got %0b",
                           want.word_first, o_out_data.word_first);
                    error_count++;
                end
                if (o_out_data.end_of_line !== want.end_of_line) begin
                    $error("end_of_line: expected %0b, got %0b",
                           want.end_of_line, o_out_data.end_of_line);
                    error_count++;
                end
                if (o_out_data.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b",
                           want.run_last, o_out_data.run_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[identifier_word_splitter_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        iws_pkg::t_in_item item;
        item.in_byte   = b;
        item.line_last = last;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_split(item);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_lines(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && sent < count; i++) begin
                send_byte(random_byte(), (i == len - 1) || (sent == count - 1));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [8:0] script[$];
        script = '{
            {8'h00, 1'b0},                     // zero byte, nothing held
            {8'hFF, 1'b0},
            {8'h80, 1'b1},                     // separator-only line
            {"X", 1'b0}, {"M", 1'b0}, {"L", 1'b0}, {"H", 1'b0},
            {"t", 1'b0}, {"t", 1'b0}, {"p", 1'b0},
            {"[", 1'b0},
            {"a", 1'b0}, {"Z", 1'b0}, {"9", 1'b0}, {"0", 1'b0},
            {"z", 1'b0}, {"{", 1'b0},
            {"/", 1'b0}, {":", 1'b0}, {"@", 1'b0},
            {"q", 1'b0}, {"R", 1'b1},          // line ends on a word byte
            {"A", 1'b0}, {8'h7F, 1'b1},        // line ends on a separator
            {"k", 1'b1}                        // one-letter line
        };
        idle_pct  = 0;
        stall_pct = 0;
        foreach (script[i])
            send_byte(script[i][8:1], script[i][0]);
        drain_results();
    endtask

    task automatic test_streaming();
        idle_pct  = 0;
        stall_pct = 0;
        send_random_lines(RANDOM_BYTES);
        drain_results();
    endtask

    task automatic test_sender_gaps();
        idle_pct  = 54;
        stall_pct = 0;
        send_random_lines(RANDOM_BYTES);
        drain_results();
    endtask

    task automatic test_receiver_stalls();
        idle_pct  = 0;
        stall_pct = 54;
        send_random_lines(RANDOM_BYTES);
        drain_results();
    endtask

    task automatic test_mixed_idling();
        idle_pct  = 11;
        stall_pct = 11;
        send_random_lines(RANDOM_BYTES);
        drain_results();
    endtask

    // Hold the output off long enough for the job queue to fill
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = HOLD_OFF_CYCLES;
        send_random_lines(24);
        drain_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        error_count  = 0;
        run_class    = RUN_LOWER;
        clear_held();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();

        if (error_count == 0)
            $display("[identifier_word_splitter_top] OK");
        else
            $display("[identifier_word_splitter_top] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/iws_pkg.sv
rtl/iws_front.sv
rtl/iws_queue.sv
rtl/iws_back.sv
rtl/identifier_word_splitter_top.sv
tb/sv/testbench.sv
